// File: design/rmsw_pkg.sv
// rmsw_pkg: shared types, widths and register codes of the rmsprop weight update
// no dependencies

package rmsw_pkg;

   localparam int ELEMENTS_DEF = 4096;
   localparam int IDX_W        = 12;
   localparam int DATA_W       = 32;
   localparam int RATE_W       = 16;
   localparam int CSR_ADDR_W   = 4;
   localparam int CSR_DATA_W   = 32;
   localparam int ROOT_W       = 28;
   localparam int RAD_W        = 56;
   localparam int QUO_W        = 56;
   localparam int SQ_STEPS     = 28;
   localparam int DIV_STEPS    = 56;

   localparam logic [RATE_W-1:0] LR_RESET    = 16'd655;
   localparam logic [RATE_W-1:0] DECAY_RESET = 16'd64881;
   localparam logic [RATE_W-1:0] EPS_RESET   = 16'd1;

   typedef enum logic [1:0] {
      REG_LEARNING_RATE = 2'd0,
      REG_DECAY         = 2'd1,
      REG_EPSILON       = 2'd2
   } csr_reg_type;

   typedef struct packed {
      logic [IDX_W-1:0]         element_index;
      logic signed [DATA_W-1:0] gradient;
      logic signed [DATA_W-1:0] weight_in;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]         element_out;
      logic signed [DATA_W-1:0] weight_out;
   } rsp_type;

   // per-item data that rides along the pipeline
   typedef struct packed {
      logic [IDX_W-1:0]         idx;
      logic                     in_range;
      logic                     gneg;
      logic [DATA_W-1:0]        gmag;
      logic signed [DATA_W-1:0] weight;
   } side_type;

endpackage

// File: design/rmsw_state.sv
// rmsw_state: mean-square memory with valid flags, clearing pass and the
// read-modify-write pipeline that computes the new mean square; uses rmsw_pkg

module rmsw_state import rmsw_pkg::*; #(
   parameter int ELEMENTS = ELEMENTS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                accept,
   input  req_type             req_data,
   input  logic [RATE_W-1:0]   decay,
   input  logic [RATE_W-1:0]   epsilon,
   output logic                busy,
   output logic                hazard,
   output logic                out_valid,
   output side_type            out_side,
   output logic [DATA_W-1:0]   out_gn
);

   localparam int AW = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
   localparam int XW = (AW > IDX_W) ? AW : IDX_W;
   localparam int CW = $clog2(ELEMENTS + 1);

   logic [DATA_W:0] mem [0:ELEMENTS-1];

   logic [CW-1:0]     clr_ff, clr_in;
   logic [DATA_W:0]   rd_ff;
   logic              v1_ff, v2_ff, v3_ff, v4_ff;
   side_type          s1_ff, s2_ff, s3_ff, s4_ff;
   side_type          s0;
   logic [DATA_W-1:0] g2_ff;
   logic [63:0]       sq2_ff;
   logic [31:0]       dec3_ff;
   logic [32:0]       ph3_ff;
   logic [48:0]       pl3_ff;
   logic [DATA_W-1:0] gn4_ff, gn3;
   logic [XW-1:0]     idx_ext;
   logic [AW-1:0]     rd_addr, wr_addr;
   logic              wr_en;
   logic [DATA_W:0]   wr_data;
   logic [16:0]       omd;
   logic [47:0]       dec_full;
   logic [65:0]       term_sum;
   logic [42:0]       g_sum;
   logic              req_in_range;

   assign busy     = (clr_ff != CW'(ELEMENTS));
   assign clr_in   = busy ? clr_ff + 1'b1 : clr_ff;
   assign idx_ext  = XW'(req_data.element_index);
   assign rd_addr  = idx_ext[AW-1:0];
   assign req_in_range = (32'(req_data.element_index) < ELEMENTS);

   always_comb begin
      s0.idx      = req_data.element_index;
      s0.in_range = req_in_range;
      s0.gneg     = req_data.gradient[DATA_W-1];
      s0.gmag     = s0.gneg ? (~req_data.gradient + 1'b1) : req_data.gradient;
      s0.weight   = req_data.weight_in;
   end

   // same element still in the read-modify-write window
   always_comb begin
      hazard = req_in_range && (
         (v1_ff && s1_ff.in_range && s1_ff.idx == req_data.element_index) ||
         (v2_ff && s2_ff.in_range && s2_ff.idx == req_data.element_index) ||
         (v3_ff && s3_ff.in_range && s3_ff.idx == req_data.element_index));
   end

   assign omd      = 17'(18'd65536 - 18'(decay));
   assign dec_full = 48'(g2_ff) * 48'(decay);
   assign term_sum = (66'(ph3_ff) << 32) + 66'(pl3_ff);
   assign g_sum    = 43'(dec3_ff) + 43'(term_sum[65:24]);
   assign gn3      = (|g_sum[42:32]) ? '1 : g_sum[31:0];

   always_comb begin
      if (busy) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff[AW-1:0];
         wr_data = '0;
      end else begin
         wr_en   = adv && v3_ff && s3_ff.in_range;
         wr_addr = AW'(XW'(s3_ff.idx));
         wr_data = {1'b1, gn3};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (adv) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         v4_ff  <= 1'b0;
      end else begin
         clr_ff <= clr_in;
         if (adv) begin
            v1_ff <= accept;
            v2_ff <= v1_ff;
            v3_ff <= v2_ff;
            v4_ff <= v3_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff   <= s0;
         s2_ff   <= s1_ff;
         g2_ff   <= rd_ff[DATA_W] ? rd_ff[DATA_W-1:0] : DATA_W'(epsilon);
         sq2_ff  <= 64'(s1_ff.gmag) * 64'(s1_ff.gmag);
         s3_ff   <= s2_ff;
         dec3_ff <= dec_full[47:16];
         ph3_ff  <= 33'(sq2_ff[63:48]) * 33'(omd);
         pl3_ff  <= 49'(sq2_ff[47:16]) * 49'(omd);
         s4_ff   <= s3_ff;
         gn4_ff  <= gn3;
      end
   end

   assign out_valid = v4_ff;
   assign out_side  = s4_ff;
   assign out_gn    = gn4_ff;

endmodule

// File: design/rmsw_sqrt.sv
// rmsw_sqrt: pipelined integer square root, one result bit per stage
// uses rmsw_pkg

module rmsw_sqrt import rmsw_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  side_type          in_side,
   input  logic [DATA_W-1:0] in_gn,
   output logic              out_valid,
   output side_type          out_side,
   output logic [ROOT_W-1:0] out_root
);

   logic              v_ff    [0:SQ_STEPS-1];
   side_type          side_ff [0:SQ_STEPS-1];
   logic [29:0]       rem_ff  [0:SQ_STEPS-1];
   logic [ROOT_W-1:0] root_ff [0:SQ_STEPS-1];
   logic [RAD_W-1:0]  rad_ff  [0:SQ_STEPS-1];

   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
      logic              v_src;
      side_type          side_src;
      logic [29:0]       rem_src, rem_in;
      logic [ROOT_W-1:0] root_src, root_in;
      logic [RAD_W-1:0]  rad_src, rad_in;
      logic [31:0]       shifted, test;
      logic              ge;

      if (k == 0) begin : g_first
         assign v_src    = in_valid;
         assign side_src = in_side;
         assign rem_src  = '0;
         assign root_src = '0;
         assign rad_src  = {in_gn, 24'b0};
      end else begin : g_next
         assign v_src    = v_ff[k-1];
         assign side_src = side_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign root_src = root_ff[k-1];
         assign rad_src  = rad_ff[k-1];
      end

      assign shifted = {rem_src, rad_src[RAD_W-1 -: 2]};
      assign test    = {2'b00, root_src, 2'b01};
      assign ge      = (shifted >= test);
      assign rem_in  = ge ? 30'(shifted - test) : shifted[29:0];
      assign root_in = {root_src[ROOT_W-2:0], ge};
      assign rad_in  = {rad_src[RAD_W-3:0], 2'b00};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (adv) begin
            v_ff[k] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            side_ff[k] <= side_src;
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            rad_ff[k]  <= rad_in;
         end
      end
   end

   // a zero root counts as one lsb
   assign out_valid = v_ff[SQ_STEPS-1];
   assign out_side  = side_ff[SQ_STEPS-1];
   assign out_root  = (root_ff[SQ_STEPS-1] == '0) ? ROOT_W'(1) : root_ff[SQ_STEPS-1];

endmodule

// File: design/rmsw_div.sv
// rmsw_div: pipelined restoring divider, |grad|*2^24 over the root,
// one quotient bit per stage; uses rmsw_pkg

module rmsw_div import rmsw_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  side_type          in_side,
   input  logic [ROOT_W-1:0] in_root,
   output logic              out_valid,
   output side_type          out_side,
   output logic [QUO_W-1:0]  out_quo
);

   logic              v_ff    [0:DIV_STEPS-1];
   side_type          side_ff [0:DIV_STEPS-1];
   logic [ROOT_W:0]   rem_ff  [0:DIV_STEPS-1];
   logic [QUO_W-1:0]  nq_ff   [0:DIV_STEPS-1];
   logic [ROOT_W-1:0] d_ff    [0:DIV_STEPS-1];

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      logic              v_src;
      side_type          side_src;
      logic [ROOT_W:0]   rem_src, rem_in;
      logic [QUO_W-1:0]  nq_src, nq_in;
      logic [ROOT_W-1:0] d_src;
      logic [ROOT_W+1:0] sh;
      logic              ge;

      if (k == 0) begin : g_first
         assign v_src    = in_valid;
         assign side_src = in_side;
         assign rem_src  = '0;
         assign nq_src   = {in_side.gmag, 24'b0};
         assign d_src    = in_root;
      end else begin : g_next
         assign v_src    = v_ff[k-1];
         assign side_src = side_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign nq_src   = nq_ff[k-1];
         assign d_src    = d_ff[k-1];
      end

      assign sh     = {rem_src, nq_src[QUO_W-1]};
      assign ge     = (sh >= {2'b00, d_src});
      assign rem_in = ge ? (ROOT_W+1)'(sh - {2'b00, d_src}) : sh[ROOT_W:0];
      assign nq_in  = {nq_src[QUO_W-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (adv) begin
            v_ff[k] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            side_ff[k] <= side_src;
            rem_ff[k]  <= rem_in;
            nq_ff[k]   <= nq_in;
            d_ff[k]    <= d_src;
         end
      end
   end

   assign out_valid = v_ff[DIV_STEPS-1];
   assign out_side  = side_ff[DIV_STEPS-1];
   assign out_quo   = nq_ff[DIV_STEPS-1];

endmodule

// File: design/rmsprop_weight_update.sv
// rmsprop_weight_update: top level, csr registers, final scaling and output register
// uses rmsw_pkg, rmsw_state, rmsw_sqrt, rmsw_div

// One update per clock for distinct elements, while the output is not stalled and the
// clearing pass is done. From the input transfer an item moves through 91 registers:
// four in the mean-square read-modify-write, 28 in the square root, 56 in the divider,
// two for the rate scaling and one output register. An item whose element is still in
// the three-stage read-modify-write window of the mean-square memory waits until that
// write is done. After reset the valid flags are cleared one entry per cycle, and no
// item is taken during this clearing pass. The pipeline holds only while a result
// waits and the last stage is full.

module rmsprop_weight_update import rmsw_pkg::*; #(
   parameter int ELEMENTS = ELEMENTS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [CSR_ADDR_W-1:0]  paddr,
   input  logic [CSR_DATA_W-1:0]  pwdata,
   output logic [CSR_DATA_W-1:0]  prdata,
   output logic                   pready
);

   logic [RATE_W-1:0] lr_ff, decay_ff, eps_ff;
   logic              adv, accept, out_load, busy, hazard;
   logic              st_valid, sq_valid, dv_valid;
   side_type          st_side, sq_side, dv_side, f1_side_ff, f2_side_ff;
   logic [DATA_W-1:0] st_gn;
   logic [ROOT_W-1:0] sq_root;
   logic [QUO_W-1:0]  dv_quo;
   logic              f1_v_ff, f2_v_ff, rsp_v_ff;
   logic [39:0]       phi_ff;
   logic [47:0]       plo_ff;
   logic [55:0]       delta_ff;
   rsp_type           rsp_ff, rsp_in;
   logic signed [57:0] w_ext, d_ext, res;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff    <= LR_RESET;
         decay_ff <= DECAY_RESET;
         eps_ff   <= EPS_RESET;
      end else if (psel && penable && pwrite) begin
         case (paddr[3:2])
            REG_LEARNING_RATE: lr_ff    <= pwdata[RATE_W-1:0];
            REG_DECAY:         decay_ff <= pwdata[RATE_W-1:0];
            REG_EPSILON:       eps_ff   <= pwdata[RATE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_LEARNING_RATE: prdata = CSR_DATA_W'(lr_ff);
         REG_DECAY:         prdata = CSR_DATA_W'(decay_ff);
         REG_EPSILON:       prdata = CSR_DATA_W'(eps_ff);
         default:           prdata = '0;
      endcase
   end

   assign out_load  = !rsp_v_ff || !rsp_stall;
   assign adv       = out_load || !f2_v_ff;
   assign req_stall = busy || !adv || hazard;
   assign accept    = req_valid && !req_stall;

   rmsw_state #(.ELEMENTS(ELEMENTS)) u_state (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .accept    (accept),
      .req_data  (req_data),
      .decay     (decay_ff),
      .epsilon   (eps_ff),
      .busy      (busy),
      .hazard    (hazard),
      .out_valid (st_valid),
      .out_side  (st_side),
      .out_gn    (st_gn)
   );

   rmsw_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (st_valid),
      .in_side   (st_side),
      .in_gn     (st_gn),
      .out_valid (sq_valid),
      .out_side  (sq_side),
      .out_root  (sq_root)
   );

   rmsw_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (sq_valid),
      .in_side   (sq_side),
      .in_root   (sq_root),
      .out_valid (dv_valid),
      .out_side  (dv_side),
      .out_quo   (dv_quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_v_ff  <= 1'b0;
         f2_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         if (adv) begin
            f1_v_ff <= dv_valid;
            f2_v_ff <= f1_v_ff;
         end
         if (out_load) begin
            rsp_v_ff <= f2_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f1_side_ff <= dv_side;
         phi_ff     <= 40'(dv_quo[55:32]) * 40'(lr_ff);
         plo_ff     <= 48'(dv_quo[31:0]) * 48'(lr_ff);
         f2_side_ff <= f1_side_ff;
         delta_ff   <= (56'(phi_ff) << 16) + 56'(plo_ff[47:16]);
      end
      if (out_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign w_ext = 58'(f2_side_ff.weight);
   assign d_ext = $signed({2'b00, delta_ff});
   assign res   = f2_side_ff.gneg ? (w_ext + d_ext) : (w_ext - d_ext);

   always_comb begin
      rsp_in.element_out = f2_side_ff.idx;
      if (!f2_side_ff.in_range) begin
         rsp_in.weight_out = f2_side_ff.weight;
      end else if (res > 58'sd2147483647) begin
         rsp_in.weight_out = 32'sh7FFFFFFF;
      end else if (res < -58'sd2147483648) begin
         rsp_in.weight_out = 32'sh80000000;
      end else begin
         rsp_in.weight_out = res[31:0];
      end
   end

   assign rsp_valid = rsp_v_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: bench/rmsw_checker.sv
// rmsw_checker: watches the request and result transfers of the rmsprop weight update,
// predicts each updated weight from its own copy of the mean-square state and compares
// depends on rmsw_pkg

module rmsw_checker import rmsw_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  rsp_type     rsp_data,
   input  logic [15:0] learning_rate,
   input  logic [15:0] decay,
   input  logic [15:0] epsilon,
   output int          failures,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [31:0] mean_sq [ELEMENTS_DEF];
   bit          touched [ELEMENTS_DEF];
   rsp_type     expected_updates [$];

   function automatic logic [63:0] root64(input logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic rsp_type predict_update(input req_type r);
      rsp_type     o;
      logic        neg;
      logic [63:0] mag, g, gn, s, q, delta;
      longint      w;
      neg = r.gradient[31];
      mag = neg ? (64'd1 << 32) - {32'd0, r.gradient} : {32'd0, r.gradient};
      w = longint'(r.weight_in);
      g = touched[r.element_index] ? {32'd0, mean_sq[r.element_index]} : {48'd0, epsilon};
      gn = ((g * decay) >> 16) + ((((mag * mag) >> 16) * (64'd65536 - decay)) >> 24);
      if (gn > 64'hFFFF_FFFF) gn = 64'hFFFF_FFFF;
      mean_sq[r.element_index] = gn[31:0];
      touched[r.element_index] = 1;
      s = root64(gn << 24);
      if (s == 0) s = 1;
      q = (mag << 24) / s;
      delta = (q >> 16) * learning_rate + (((q & 64'hFFFF) * learning_rate) >> 16);
      w = neg ? w + longint'(delta) : w - longint'(delta);
      if (w > 64'sd2147483647) w = 64'sd2147483647;
      if (w < -64'sd2147483648) w = -64'sd2147483648;
      o.element_out = r.element_index;
      o.weight_out = w[31:0];
      return o;
   endfunction

   assign pending = expected_updates.size();

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         failures <= 0;
         foreach (touched[i]) touched[i] = 0;
      end else begin
         if (req_valid && !req_stall) expected_updates.push_back(predict_update(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (expected_updates.size() == 0) begin
               if (failures < 10) $display("unexpected result %h", rsp_data);
               failures <= failures + 1;
            end else begin
               e = expected_updates.pop_front();
               if (e !== rsp_data) begin
                  if (failures < 10)
                     $display("mismatch: expected idx %0d w %h, got idx %0d w %h",
                              e.element_out, e.weight_out, rsp_data.element_out,
                              rsp_data.weight_out);
                  failures <= failures + 1;
               end
            end
         end
      end
   end
endmodule

// File: bench/testbench.sv
// testbench: stimulus, csr writes and verdict for the rmsprop weight update
// depends on rmsw_pkg, rmsprop_weight_update and rmsw_checker

module testbench;
   import rmsw_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_stall, rsp_valid, rsp_stall = 0;
   req_type req_data = '0;
   rsp_type rsp_data;
   logic psel = 0, penable = 0, pwrite = 0, pready;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0, prdata;
   logic [15:0] learning_rate = LR_RESET, decay = DECAY_RESET, epsilon = EPS_RESET;
   int failures, pending;
   int send_idle = 0, recv_stall = 0;
   bit hold_off = 0;

   always #10 clock = ~clock;

   rmsprop_weight_update DUT (.*);
   rmsw_checker checker_inst (.*);

   initial begin
      #20ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   always @(posedge clock) begin
      if (hold_off) rsp_stall <= 1;
      else rsp_stall <= ($urandom_range(99) < recv_stall);
   end

   task automatic write_csr(input csr_reg_type r, input logic [15:0] v);
      psel <= 1; pwrite <= 1; paddr <= CSR_ADDR_W'(4 * r); pwdata <= CSR_DATA_W'(v);
      @(posedge clock);
      penable <= 1;
      do @(posedge clock); while (!pready);
      psel <= 0; penable <= 0; pwrite <= 0;
      case (r)
         REG_LEARNING_RATE: learning_rate = v;
         REG_DECAY:         decay = v;
         default:           epsilon = v;
      endcase
   endtask

   task automatic send_update(input logic [11:0] idx, input logic [31:0] grad,
                              input logic [31:0] w);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_data <= '{idx, grad, w};
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain;
      req_valid <= 0;
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_grad;
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(4095)) - 2048);
         2: return 32'($signed($urandom_range(1 << 25)) - (1 << 24));
         default: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      endcase
   endfunction

   initial begin
      logic [15:0] settings [4][3];
      settings = '{'{655, 64881, 1}, '{65535, 0, 0}, '{0, 65535, 65535},
                   '{1234, 32768, 100}};
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_update(0, 32'h7FFF_FFFF, 32'h8000_0000);
      send_update(0, 32'h8000_0000, 32'h7FFF_FFFF);
      send_update(4095, 0, 32'h1234_5678);
      send_update(4095, 32'h0100_0000, 32'h0);
      send_update(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_update(2, 1, 32'h7FFF_FFFF);
      send_update(3, 32'h8000_0000, 32'h7FFF_FFF0);
      drain();
      write_csr(REG_EPSILON, 0);
      write_csr(REG_LEARNING_RATE, 16'hFFFF);
      send_update(10, 0, 32'h8000_0000);
      send_update(11, 1, 32'h8000_0000);
      send_update(12, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
      drain();
      for (int ph = 0; ph < 4; ph++) begin
         write_csr(REG_LEARNING_RATE, settings[ph][0]);
         write_csr(REG_DECAY, settings[ph][1]);
         write_csr(REG_EPSILON, settings[ph][2]);
         send_idle = (ph == 1 || ph == 3) ? (ph == 1 ? 63 : 27) : 0;
         recv_stall = (ph == 2 || ph == 3) ? (ph == 2 ? 63 : 27) : 0;
         if (ph == 0) fork
            begin
               hold_off = 1;
               repeat (200) @(posedge clock);
               hold_off = 0;
            end
         join_none
         for (int n = 0; n < 450; n++)
            send_update(12'($urandom_range(1) ? $urandom_range(15) : $urandom_range(4095)),
                        rand_grad(), $urandom);
         drain();
      end
      if (failures == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
